/* rtl/slx_pkg.sv */
// ----------------------------------------------------------------------------
// slx_pkg
// Shared types, scan modes, result kinds and character codes of the lexeme
// splitter.
// ----------------------------------------------------------------------------
package slx_pkg;

    // Scan modes
    localparam logic [3:0] M_IDLE       = 4'd0;
    localparam logic [3:0] M_WORD       = 4'd1;
    localparam logic [3:0] M_STR        = 4'd2;
    localparam logic [3:0] M_STR_END    = 4'd3;
    localparam logic [3:0] M_CONT       = 4'd4;
    localparam logic [3:0] M_CONT_CR    = 4'd5;
    localparam logic [3:0] M_BLOCK      = 4'd6;
    localparam logic [3:0] M_BLOCK_TAIL = 4'd7;
    localparam logic [3:0] M_LINE_CMT   = 4'd8;
    localparam logic [3:0] M_DONE       = 4'd9;

    // Result kinds
    localparam logic [1:0] K_CHAR  = 2'd0;
    localparam logic [1:0] K_END   = 2'd1;
    localparam logic [1:0] K_ERROR = 2'd2;
    localparam logic [1:0] K_EOI   = 2'd3;

    // Error codes
    localparam logic [1:0] E_NONE       = 2'd0;
    localparam logic [1:0] E_EMPTY_CONT = 2'd1;
    localparam logic [1:0] E_COMMENT    = 2'd2;
    localparam logic [1:0] E_DELIM      = 2'd3;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_Z      = 8'h5A;
    localparam logic [7:0] CH_ELL0   = 8'hE2;
    localparam logic [7:0] CH_ELL1   = 8'h80;
    localparam logic [7:0] CH_ELL2   = 8'hA6;

    localparam int WIN_DEPTH   = 4;
    localparam int FLUSH_STEPS = 10;

    // One result without its line number.
    typedef struct packed {
        logic       last;
        logic [1:0] kind;
        logic [7:0] ch;
        logic [1:0] err;
    } res_t;

    // Results produced by the engine in one cycle.
    typedef struct packed {
        logic [2:0]      count;
        res_t [3:0]      ent;
    } push_t;

    function automatic res_t mk_res(logic [1:0] kind, logic [7:0] ch, logic [1:0] err);
        res_t r;
        r.last = 1'b0;
        r.kind = kind;
        r.ch   = ch;
        r.err  = err;
        return r;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_crlf(logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

/* rtl/slx_engine.sv */
// ----------------------------------------------------------------------------
// slx_engine
// Scan state, four-byte lookahead window and the per-cycle decision logic.
// ----------------------------------------------------------------------------
module slx_engine #(
    parameter int LINE_WIDTH = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    input  logic                  nested,
    output slx_pkg::push_t        push,
    output logic [LINE_WIDTH-1:0] push_line,
    output logic                  flushing
);

    logic [3:0]            mode_reg, mode_next;
    logic [3:0][7:0]       win_reg, win_next;
    logic [2:0]            cnt_reg, cnt_next;
    logic [LINE_WIDTH-1:0] line_reg, line_next;
    logic                  anl_reg, anl_next;
    logic [15:0]           prev_reg, prev_next;
    logic                  stop_reg, stop_next;
    logic                  flush_reg, flush_next;
    logic [3:0]            guard_reg, guard_next;

    slx_pkg::push_t        push_c;

    always_comb begin
        logic [3:0]      m;
        logic [3:0][7:0] w;
        logic [2:0]      cnt;
        logic [3:0][7:0] pk;
        logic [7:0]      c;
        logic            dodec, fin, step_end, dn, clr, esc, ellip, delim;
        logic [2:0]      nc, nsh;
        logic [2:0]      nres;

        m        = mode_reg;
        w        = win_reg;
        cnt      = cnt_reg;
        line_next = line_reg;
        anl_next = anl_reg;
        prev_next = prev_reg;
        stop_next = stop_reg;
        flush_next = flush_reg;
        guard_next = guard_reg;
        dodec    = 1'b0;
        fin      = 1'b0;
        step_end = 1'b0;
        dn       = 1'b0;
        clr      = 1'b0;
        esc      = 1'b0;
        nc       = 3'd0;
        nsh      = 3'd0;
        nres     = 3'd0;
        push_c   = '0;

        if (in_valid) begin
            if ((m != slx_pkg::M_DONE) && (cnt < 3'(slx_pkg::WIN_DEPTH))) begin
                w[cnt[1:0]] = in_byte;
                cnt = cnt + 3'd1;
            end
            if (!in_last) begin
                dodec    = (cnt >= 3'(slx_pkg::WIN_DEPTH)) && (m != slx_pkg::M_DONE);
                step_end = 1'b1;
            end else begin
                flush_next = 1'b1;
                guard_next = 4'd0;
            end
        end
        if (flush_next) begin
            if ((guard_next < 4'(slx_pkg::FLUSH_STEPS)) && (m != slx_pkg::M_DONE)) begin
                dodec = 1'b1;
                guard_next = guard_next + 4'd1;
            end else begin
                fin = 1'b1;
            end
        end

        for (int i = 0; i < 4; i++) begin
            pk[i] = (3'(i) < cnt) ? w[i] : slx_pkg::CH_NUL;
        end
        c = pk[0];
        ellip = ((c == slx_pkg::CH_DOT) && (pk[1] == slx_pkg::CH_DOT) &&
                 (pk[2] == slx_pkg::CH_DOT)) ||
                ((c == slx_pkg::CH_ELL0) && (pk[1] == slx_pkg::CH_ELL1) &&
                 (pk[2] == slx_pkg::CH_ELL2));
        delim = (c == slx_pkg::CH_NUL) || slx_pkg::is_space(c) ||
                (c == slx_pkg::CH_COMMA) || (c == slx_pkg::CH_BANG) ||
                ((c == slx_pkg::CH_APOS) && (pk[1] == slx_pkg::CH_Z)) || ellip;

        if (dodec) begin
            // Modes are tested in the order in which one falls into the next,
            // so a single pass covers every chained transition.
            if (m == slx_pkg::M_STR) begin
                if ((c == slx_pkg::CH_NUL) || slx_pkg::is_crlf(c)) begin
                    m = slx_pkg::M_STR_END;
                end else begin
                    esc = (prev_reg[7:0] == slx_pkg::CH_COLON) &&
                          (prev_reg[15:8] != slx_pkg::CH_COLON);
                    push_c.ent[nres[1:0]] = slx_pkg::mk_res(slx_pkg::K_CHAR, c,
                                                            slx_pkg::E_NONE);
                    nres = nres + 3'd1;
                    nc = 3'd1;
                    prev_next = {prev_reg[7:0], c};
                    if ((c == slx_pkg::CH_QUOTE) && !esc) m = slx_pkg::M_STR_END;
                    dn = 1'b1;
                end
            end
            if (!dn && ((m == slx_pkg::M_WORD) || (m == slx_pkg::M_STR_END))) begin
                if (delim) begin
                    push_c.ent[nres[1:0]] = slx_pkg::mk_res(slx_pkg::K_END,
                                                            slx_pkg::CH_NUL,
                                                            slx_pkg::E_NONE);
                    nres = nres + 3'd1;
                    m = slx_pkg::M_IDLE;
                end else if (m == slx_pkg::M_STR_END) begin
                    push_c.ent[nres[1:0]] = slx_pkg::mk_res(slx_pkg::K_ERROR,
                                                            slx_pkg::CH_NUL,
                                                            slx_pkg::E_DELIM);
                    nres = nres + 3'd1;
                    stop_next = 1'b1;
                    m = slx_pkg::M_DONE;
                    clr = 1'b1;
                    dn = 1'b1;
                end else begin
                    push_c.ent[nres[1:0]] = slx_pkg::mk_res(slx_pkg::K_CHAR, c,
                                                            slx_pkg::E_NONE);
                    nres = nres + 3'd1;
                    nc = 3'd1;
                    dn = 1'b1;
                end
            end
            if (!dn && (m == slx_pkg::M_CONT_CR)) begin
                m = slx_pkg::M_CONT;
                if (c == slx_pkg::CH_LF) begin
                    nc = 3'd1;
                    dn = 1'b1;
                end
            end
            if (!dn && (m == slx_pkg::M_CONT)) begin
                if (slx_pkg::is_crlf(c)) begin
                    push_c.ent[nres[1:0]] = slx_pkg::mk_res(slx_pkg::K_ERROR,
                                                            slx_pkg::CH_NUL,
                                                            slx_pkg::E_EMPTY_CONT);
                    nres = nres + 3'd1;
                    stop_next = 1'b1;
                    m = slx_pkg::M_DONE;
                    clr = 1'b1;
                    dn = 1'b1;
                end else if (slx_pkg::is_space(c)) begin
                    nc = 3'd1;
                    dn = 1'b1;
                end else begin
                    m = slx_pkg::M_IDLE;
                end
            end
            if (!dn && (m == slx_pkg::M_BLOCK)) begin
                dn = 1'b1;
                if ((c == slx_pkg::CH_T) && (pk[1] == slx_pkg::CH_L) &&
                    (pk[2] == slx_pkg::CH_D) && (pk[3] == slx_pkg::CH_R)) begin
                    m = slx_pkg::M_BLOCK_TAIL;
                    nc = 3'd4;
                end else if (c == slx_pkg::CH_NUL) begin
                    push_c.ent[nres[1:0]] = slx_pkg::mk_res(slx_pkg::K_ERROR,
                                                            slx_pkg::CH_NUL,
                                                            slx_pkg::E_COMMENT);
                    nres = nres + 3'd1;
                    stop_next = 1'b1;
                    m = slx_pkg::M_DONE;
                    clr = 1'b1;
                end else if (slx_pkg::is_crlf(c)) begin
                    if (line_reg != '1) line_next = line_reg + 1'b1;
                    nc = ((c == slx_pkg::CH_CR) && (pk[1] == slx_pkg::CH_LF)) ? 3'd2 : 3'd1;
                end else begin
                    nc = 3'd1;
                end
            end
            if (!dn && (m == slx_pkg::M_BLOCK_TAIL)) begin
                if ((c == slx_pkg::CH_COMMA) || slx_pkg::is_crlf(c)) begin
                    m = slx_pkg::M_IDLE;
                end else if (slx_pkg::is_space(c)) begin
                    nc = 3'd1;
                    dn = 1'b1;
                end else begin
                    push_c.ent[nres[1:0]] = slx_pkg::mk_res(slx_pkg::K_ERROR,
                                                            slx_pkg::CH_NUL,
                                                            slx_pkg::E_COMMENT);
                    nres = nres + 3'd1;
                    stop_next = 1'b1;
                    m = slx_pkg::M_DONE;
                    clr = 1'b1;
                    dn = 1'b1;
                end
            end
            if (!dn && (m == slx_pkg::M_LINE_CMT)) begin
                if ((c == slx_pkg::CH_NUL) || slx_pkg::is_crlf(c)) begin
                    m = slx_pkg::M_IDLE;
                end else begin
                    nc = 3'd1;
                    dn = 1'b1;
                end
            end
            if (!dn && (m == slx_pkg::M_IDLE)) begin
                if (c == slx_pkg::CH_COMMA) begin
                    push_c.ent[nres[1:0]] = slx_pkg::mk_res(slx_pkg::K_CHAR,
                                                            slx_pkg::CH_LF,
                                                            slx_pkg::E_NONE);
                    push_c.ent[nres[1:0] + 2'd1] = slx_pkg::mk_res(slx_pkg::K_END,
                                                                   slx_pkg::CH_NUL,
                                                                   slx_pkg::E_NONE);
                    nres = nres + 3'd2;
                    anl_next = 1'b1;
                    nc = 3'd1;
                end else if (c == slx_pkg::CH_BANG) begin
                    push_c.ent[nres[1:0]] = slx_pkg::mk_res(slx_pkg::K_CHAR,
                                                            slx_pkg::CH_BANG,
                                                            slx_pkg::E_NONE);
                    push_c.ent[nres[1:0] + 2'd1] = slx_pkg::mk_res(slx_pkg::K_END,
                                                                   slx_pkg::CH_NUL,
                                                                   slx_pkg::E_NONE);
                    nres = nres + 3'd2;
                    anl_next = 1'b0;
                    nc = 3'd1;
                end else if ((c == slx_pkg::CH_APOS) && (pk[1] == slx_pkg::CH_Z)) begin
                    push_c.ent[nres[1:0]] = slx_pkg::mk_res(slx_pkg::K_CHAR,
                                                            slx_pkg::CH_APOS,
                                                            slx_pkg::E_NONE);
                    push_c.ent[nres[1:0] + 2'd1] = slx_pkg::mk_res(slx_pkg::K_CHAR,
                                                                   slx_pkg::CH_Z,
                                                                   slx_pkg::E_NONE);
                    push_c.ent[nres[1:0] + 2'd2] = slx_pkg::mk_res(slx_pkg::K_END,
                                                                   slx_pkg::CH_NUL,
                                                                   slx_pkg::E_NONE);
                    nres = nres + 3'd3;
                    anl_next = 1'b0;
                    nc = 3'd2;
                end else if (slx_pkg::is_crlf(c)) begin
                    push_c.ent[nres[1:0]] = slx_pkg::mk_res(slx_pkg::K_CHAR,
                                                            slx_pkg::CH_LF,
                                                            slx_pkg::E_NONE);
                    push_c.ent[nres[1:0] + 2'd1] = slx_pkg::mk_res(slx_pkg::K_END,
                                                                   slx_pkg::CH_NUL,
                                                                   slx_pkg::E_NONE);
                    nres = nres + 3'd2;
                    anl_next = 1'b1;
                    if (line_reg != '1) line_next = line_reg + 1'b1;
                    nc = ((c == slx_pkg::CH_CR) && (pk[1] == slx_pkg::CH_LF)) ? 3'd2 : 3'd1;
                end else if (slx_pkg::is_space(c)) begin
                    nc = 3'd1;
                end else if (ellip && slx_pkg::is_crlf(pk[3])) begin
                    m = (pk[3] == slx_pkg::CH_CR) ? slx_pkg::M_CONT_CR : slx_pkg::M_CONT;
                    nc = 3'd4;
                end else if (anl_reg && (c == slx_pkg::CH_O) && (pk[1] == slx_pkg::CH_B) &&
                             (pk[2] == slx_pkg::CH_T) && (pk[3] == slx_pkg::CH_W)) begin
                    m = slx_pkg::M_BLOCK;
                    nc = 3'd4;
                end else if ((c == slx_pkg::CH_B) && (pk[1] == slx_pkg::CH_T) &&
                             (pk[2] == slx_pkg::CH_W)) begin
                    m = slx_pkg::M_LINE_CMT;
                    nc = 3'd3;
                end else if (c == slx_pkg::CH_NUL) begin
                    m = slx_pkg::M_DONE;
                    clr = 1'b1;
                end else begin
                    push_c.ent[nres[1:0]] = slx_pkg::mk_res(slx_pkg::K_CHAR, c,
                                                            slx_pkg::E_NONE);
                    nres = nres + 3'd1;
                    nc = 3'd1;
                    anl_next = 1'b0;
                    if (c == slx_pkg::CH_QUOTE) begin
                        prev_next = {8'h00, slx_pkg::CH_QUOTE};
                        m = slx_pkg::M_STR;
                    end else begin
                        m = slx_pkg::M_WORD;
                    end
                end
            end
        end

        // Drop consumed bytes from the front of the window.
        if (clr) begin
            cnt = 3'd0;
        end else begin
            nsh = (nc > cnt) ? cnt : nc;
            for (int i = 0; i < 4; i++) begin
                w[i] = ((3'(i) + nsh) < 3'(slx_pkg::WIN_DEPTH)) ? w[2'(3'(i) + nsh)] : 8'h00;
            end
            cnt = cnt - nsh;
        end

        if (fin) begin
            if (!stop_reg && !nested) begin
                push_c.ent[nres[1:0]] = slx_pkg::mk_res(slx_pkg::K_CHAR,
                                                        slx_pkg::CH_DOLLAR,
                                                        slx_pkg::E_NONE);
                push_c.ent[nres[1:0] + 2'd1] = slx_pkg::mk_res(slx_pkg::K_END,
                                                               slx_pkg::CH_NUL,
                                                               slx_pkg::E_NONE);
                nres = nres + 3'd2;
            end
            push_c.ent[nres[1:0]] = slx_pkg::mk_res(slx_pkg::K_EOI, slx_pkg::CH_NUL,
                                                    slx_pkg::E_NONE);
            nres = nres + 3'd1;
            m = slx_pkg::M_IDLE;
            w = '0;
            cnt = 3'd0;
            line_next = LINE_WIDTH'(1);
            anl_next = 1'b1;
            prev_next = 16'h0000;
            stop_next = 1'b0;
            flush_next = 1'b0;
        end

        if ((nres != 3'd0) && (step_end || fin)) begin
            push_c.ent[2'(nres - 3'd1)].last = 1'b1;
        end
        push_c.count = nres;
        mode_next = m;
        win_next  = w;
        cnt_next  = cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= slx_pkg::M_IDLE;
            win_reg   <= '0;
            cnt_reg   <= 3'd0;
            line_reg  <= LINE_WIDTH'(1);
            anl_reg   <= 1'b1;
            prev_reg  <= 16'h0000;
            stop_reg  <= 1'b0;
            flush_reg <= 1'b0;
            guard_reg <= 4'd0;
        end else begin
            mode_reg  <= mode_next;
            win_reg   <= win_next;
            cnt_reg   <= cnt_next;
            line_reg  <= line_next;
            anl_reg   <= anl_next;
            prev_reg  <= prev_next;
            stop_reg  <= stop_next;
            flush_reg <= flush_next;
            guard_reg <= guard_next;
        end
    end

    assign push      = push_c;
    assign push_line = line_reg;
    assign flushing  = flush_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'(slx_pkg::WIN_DEPTH))
        else $error("lookahead window count out of range");
    a_stop_done: assert property (@(posedge aclk) disable iff (!aresetn)
        stop_reg |-> (mode_reg == slx_pkg::M_DONE))
        else $error("stopped scan left the done mode");
    a_no_item_in_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_reg |-> !in_valid)
        else $error("byte delivered while the buffer end is flushed");
    a_push_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        push_c.count <= 3'd4)
        else $error("more than four results in one cycle");

endmodule

/* rtl/slx_result_fifo.sv */
// ----------------------------------------------------------------------------
// slx_result_fifo
// Result queue: takes up to four entries per cycle, hands out one per cycle while popped.
// ----------------------------------------------------------------------------
module slx_result_fifo #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [2:0]                 push_count,
    input  logic [3:0][WIDTH-1:0]      push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           head_data,
    output logic                       not_empty,
    output logic [$clog2(DEPTH):0]     level
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW:0]      wr_reg, wr_next;
    logic [AW:0]      rd_reg, rd_next;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < push_count) begin
                mem[AW'(wr_reg[AW-1:0] + AW'(i))] <= push_data[i];
            end
        end
    end

    assign wr_next = wr_reg + (AW+1)'(push_count);
    assign rd_next = rd_reg + (AW+1)'(pop && not_empty);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
        end else begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
        end
    end

    assign level     = wr_reg - rd_reg;
    assign not_empty = (wr_reg != rd_reg);
    assign head_data = mem[rd_reg[AW-1:0]];

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= (AW+1)'(DEPTH))
        else $error("result queue overflow");
    a_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ((level + (AW+1)'(push_count)) <= (AW+1)'(DEPTH)) || (push_count == 3'd0))
        else $error("push into a full result queue");
    a_head_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (not_empty && !pop) |=> (rd_reg == $past(rd_reg)))
        else $error("read pointer moved without a pop");

endmodule

/* rtl/script_lexeme_splitter.sv */
// ----------------------------------------------------------------------------
// script_lexeme_splitter
// Splits a source byte stream into tagged lexeme characters, end markers,
// errors and end-of-input results, each with its source line.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  tdata[7:0] data_byte, tlast last_byte
// m_axis    out  m_tvalid/m_tready  tdata char, line, error; tuser kind; tlast
// apb       in   psel/penable       register 0 at 0x0: nested_source
//
// A byte is taken in every cycle while the result queue has room; it is
// registered and joins the lookahead window in the next cycle. The final
// byte of a buffer flushes the lookahead window, one decision a cycle,
// during which no byte is taken. Results leave one per cycle while popped,
// from a 32-entry queue. Reset is synchronous and clears all scan state.
// ----------------------------------------------------------------------------
module script_lexeme_splitter #(
    parameter int LINE_WIDTH = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    // lexeme_char, line_number, error_code from bit 0 up, zero padded
    output logic [((8 + LINE_WIDTH + 2 + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [1:0]  m_tuser,   // item_kind
    output logic        m_tlast,   // run_last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW    = ((8 + LINE_WIDTH + 2 + 7) / 8) * 8;
    localparam int EW    = 1 + 2 + 8 + 2 + LINE_WIDTH;
    localparam int DEPTH = 32;
    localparam int LW    = $clog2(DEPTH);
    localparam logic [LW:0] ACCEPT_LEVEL = (LW+1)'(DEPTH - 16);

    logic                  nested_reg;
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    slx_pkg::push_t        push;
    logic [LINE_WIDTH-1:0] push_line;
    logic                  flushing;
    logic [3:0][EW-1:0]    push_data;
    logic [EW-1:0]         head;
    logic                  not_empty;
    logic [LW:0]           level;
    logic                  s_acc;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'b0, nested_reg} : 32'h0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nested_reg <= 1'b0;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            nested_reg <= pwdata[0];
        end
    end

    // Room is kept for the registered byte and a full buffer-end flush.
    assign s_tready = !flushing && !(in_valid_reg && in_last_reg) && (level <= ACCEPT_LEVEL);
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    slx_engine #(.LINE_WIDTH(LINE_WIDTH)) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .nested    (nested_reg),
        .push      (push),
        .push_line (push_line),
        .flushing  (flushing)
    );

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            push_data[i] = {push.ent[i].last, push.ent[i].kind, push.ent[i].err,
                            push_line, push.ent[i].ch};
        end
    end

    slx_result_fifo #(.WIDTH(EW), .DEPTH(DEPTH)) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push.count),
        .push_data  (push_data),
        .pop        (m_tready),
        .head_data  (head),
        .not_empty  (not_empty),
        .level      (level)
    );

    assign m_tvalid = not_empty;
    assign m_tlast  = head[EW-1];
    assign m_tuser  = head[EW-2:EW-3];
    assign m_tdata  = DW'(head[EW-4:0]);

endmodule

/* tb/sv/slx_lexeme_checker.sv */
// ----------------------------------------------------------------------------
// slx_lexeme_checker
// Watches the byte input, the result stream and register writes of the
// lexeme splitter, predicts every result item and compares it field by field.
// ----------------------------------------------------------------------------
module slx_lexeme_checker #(
    parameter int LINE_WIDTH = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [7:0] char, [27:8] line, [29:28] error
    input  logic [1:0]  m_tuser,   // item_kind
    input  logic        m_tlast,   // run_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending,
    output int          seen_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEP_MAX = 12;

    typedef struct packed {
        logic [1:0]            kind;
        logic [7:0]            ch;
        logic [LINE_WIDTH-1:0] line;
        logic [1:0]            err;
        logic                  last;
    } lexeme_res_t;

    lexeme_res_t expected_q[$];
    lexeme_res_t step_res[STEP_MAX];
    int          step_n;

    // Scanner state of the prediction.
    logic                  nested;
    logic [3:0]            mode;
    logic [7:0]            win[4];
    int                    wcount;
    logic [LINE_WIDTH-1:0] line;
    logic                  after_nl;
    logic [15:0]           prev2;
    logic                  stopped;

    function automatic void put(logic [1:0] kind, logic [7:0] ch, logic [1:0] err);
        if (step_n < STEP_MAX) begin
            step_res[step_n] = '{kind, ch, line, err, 1'b0};
            step_n++;
        end
    endfunction

    function automatic logic [7:0] peek(int i);
        return (i < wcount) ? win[i] : 8'h00;
    endfunction

    function automatic void consume(int n);
        if (n > wcount) n = wcount;
        for (int i = 0; i < 4; i++) begin
            if (i + n < 4) win[i] = win[i + n];
        end
        wcount -= n;
    endfunction

    function automatic logic blank(logic [7:0] c);
        return c == slx_pkg::CH_SPACE || (c >= slx_pkg::CH_TAB && c <= slx_pkg::CH_CR);
    endfunction

    function automatic logic line_break(logic [7:0] c);
        return c == slx_pkg::CH_CR || c == slx_pkg::CH_LF;
    endfunction

    function automatic logic ellipsis_ahead();
        return (peek(0) == slx_pkg::CH_DOT && peek(1) == slx_pkg::CH_DOT &&
                peek(2) == slx_pkg::CH_DOT) ||
               (peek(0) == slx_pkg::CH_ELL0 && peek(1) == slx_pkg::CH_ELL1 &&
                peek(2) == slx_pkg::CH_ELL2);
    endfunction

    function automatic logic delimiter_ahead();
        logic [7:0] c;
        c = peek(0);
        return c == slx_pkg::CH_NUL || blank(c) || c == slx_pkg::CH_COMMA ||
               c == slx_pkg::CH_BANG ||
               (c == slx_pkg::CH_APOS && peek(1) == slx_pkg::CH_Z) || ellipsis_ahead();
    endfunction

    function automatic void line_up();
        if (line != {LINE_WIDTH{1'b1}}) line++;
    endfunction

    function automatic void abort_scan(logic [1:0] code);
        put(slx_pkg::K_ERROR, 8'h00, code);
        stopped = 1'b1;
        mode    = slx_pkg::M_DONE;
        wcount  = 0;
    endfunction

    function automatic void newline_lexeme();
        put(slx_pkg::K_CHAR, slx_pkg::CH_LF, slx_pkg::E_NONE);
        put(slx_pkg::K_END, 8'h00, slx_pkg::E_NONE);
        after_nl = 1'b1;
    endfunction

    function automatic void decide_between(logic [7:0] c);
        logic [7:0] p3;
        p3 = peek(3);
        if (c == slx_pkg::CH_COMMA) begin
            newline_lexeme();
            consume(1);
        end else if (c == slx_pkg::CH_BANG) begin
            put(slx_pkg::K_CHAR, slx_pkg::CH_BANG, slx_pkg::E_NONE);
            put(slx_pkg::K_END, 8'h00, slx_pkg::E_NONE);
            after_nl = 1'b0;
            consume(1);
        end else if (c == slx_pkg::CH_APOS && peek(1) == slx_pkg::CH_Z) begin
            put(slx_pkg::K_CHAR, slx_pkg::CH_APOS, slx_pkg::E_NONE);
            put(slx_pkg::K_CHAR, slx_pkg::CH_Z, slx_pkg::E_NONE);
            put(slx_pkg::K_END, 8'h00, slx_pkg::E_NONE);
            after_nl = 1'b0;
            consume(2);
        end else if (line_break(c)) begin
            newline_lexeme();
            line_up();
            consume((c == slx_pkg::CH_CR && peek(1) == slx_pkg::CH_LF) ? 2 : 1);
        end else if (blank(c)) begin
            consume(1);
        end else if (ellipsis_ahead() && line_break(p3)) begin
            mode = (p3 == slx_pkg::CH_CR) ? slx_pkg::M_CONT_CR : slx_pkg::M_CONT;
            consume(4);
        end else if (after_nl && c == slx_pkg::CH_O && peek(1) == slx_pkg::CH_B &&
                     peek(2) == slx_pkg::CH_T && p3 == slx_pkg::CH_W) begin
            mode = slx_pkg::M_BLOCK;
            consume(4);
        end else if (c == slx_pkg::CH_B && peek(1) == slx_pkg::CH_T &&
                     peek(2) == slx_pkg::CH_W) begin
            mode = slx_pkg::M_LINE_CMT;
            consume(3);
        end else if (c == slx_pkg::CH_NUL) begin
            mode   = slx_pkg::M_DONE;
            wcount = 0;
        end else begin
            put(slx_pkg::K_CHAR, c, slx_pkg::E_NONE);
            consume(1);
            after_nl = 1'b0;
            if (c == slx_pkg::CH_QUOTE) begin
                prev2 = {8'h00, slx_pkg::CH_QUOTE};
                mode  = slx_pkg::M_STR;
            end else begin
                mode = slx_pkg::M_WORD;
            end
        end
    endfunction

    // One decision; the loop only repeats when a mode hands the same byte on.
    function automatic void decide();
        logic [7:0] c;
        logic       escaped;
        while (1'b1) begin
            c = peek(0);
            case (mode)
                slx_pkg::M_WORD, slx_pkg::M_STR_END: begin
                    if (delimiter_ahead()) begin
                        put(slx_pkg::K_END, 8'h00, slx_pkg::E_NONE);
                        mode = slx_pkg::M_IDLE;
                        continue;
                    end
                    if (mode == slx_pkg::M_STR_END) begin
                        abort_scan(slx_pkg::E_DELIM);
                        return;
                    end
                    put(slx_pkg::K_CHAR, c, slx_pkg::E_NONE);
                    consume(1);
                    return;
                end
                slx_pkg::M_STR: begin
                    if (c == slx_pkg::CH_NUL || line_break(c)) begin
                        mode = slx_pkg::M_STR_END;
                        continue;
                    end
                    escaped = prev2[7:0] == slx_pkg::CH_COLON &&
                              prev2[15:8] != slx_pkg::CH_COLON;
                    put(slx_pkg::K_CHAR, c, slx_pkg::E_NONE);
                    consume(1);
                    prev2 = {prev2[7:0], c};
                    if (c == slx_pkg::CH_QUOTE && !escaped) mode = slx_pkg::M_STR_END;
                    return;
                end
                slx_pkg::M_CONT_CR: begin
                    mode = slx_pkg::M_CONT;
                    if (c == slx_pkg::CH_LF) begin
                        consume(1);
                        return;
                    end
                    continue;
                end
                slx_pkg::M_CONT: begin
                    if (line_break(c)) begin
                        abort_scan(slx_pkg::E_EMPTY_CONT);
                        return;
                    end
                    if (blank(c)) begin
                        consume(1);
                        return;
                    end
                    mode = slx_pkg::M_IDLE;
                    continue;
                end
                slx_pkg::M_BLOCK: begin
                    if (c == slx_pkg::CH_T && peek(1) == slx_pkg::CH_L &&
                        peek(2) == slx_pkg::CH_D && peek(3) == slx_pkg::CH_R) begin
                        mode = slx_pkg::M_BLOCK_TAIL;
                        consume(4);
                    end else if (c == slx_pkg::CH_NUL) begin
                        abort_scan(slx_pkg::E_COMMENT);
                    end else if (line_break(c)) begin
                        line_up();
                        consume((c == slx_pkg::CH_CR && peek(1) == slx_pkg::CH_LF) ? 2 : 1);
                    end else begin
                        consume(1);
                    end
                    return;
                end
                slx_pkg::M_BLOCK_TAIL: begin
                    if (c == slx_pkg::CH_COMMA || line_break(c)) begin
                        mode = slx_pkg::M_IDLE;
                        continue;
                    end
                    if (blank(c)) consume(1);
                    else abort_scan(slx_pkg::E_COMMENT);
                    return;
                end
                slx_pkg::M_LINE_CMT: begin
                    if (c == slx_pkg::CH_NUL || line_break(c)) begin
                        mode = slx_pkg::M_IDLE;
                        continue;
                    end
                    consume(1);
                    return;
                end
                slx_pkg::M_IDLE: begin
                    decide_between(c);
                    return;
                end
                default: return;
            endcase
        end
    endfunction

    function automatic void restart_scan();
        mode     = slx_pkg::M_IDLE;
        wcount   = 0;
        line     = LINE_WIDTH'(1);
        after_nl = 1'b1;
        prev2    = 16'h0000;
        stopped  = 1'b0;
        for (int i = 0; i < 4; i++) win[i] = 8'h00;
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic fin);
        step_n = 0;
        if (mode != slx_pkg::M_DONE && wcount < 4) begin
            win[wcount] = b;
            wcount++;
        end
        if (!fin) begin
            if (wcount >= 4 && mode != slx_pkg::M_DONE) decide();
        end else begin
            for (int g = 0; g < 10 && mode != slx_pkg::M_DONE; g++) decide();
            if (!stopped && !nested) begin
                put(slx_pkg::K_CHAR, slx_pkg::CH_DOLLAR, slx_pkg::E_NONE);
                put(slx_pkg::K_END, 8'h00, slx_pkg::E_NONE);
            end
            put(slx_pkg::K_EOI, 8'h00, slx_pkg::E_NONE);
            restart_scan();
        end
        if (step_n > 0) step_res[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++) expected_q.push_back(step_res[i]);
    endfunction

    lexeme_res_t got, want;

    initial begin
        errors       = 0;
        seen_results = 0;
        nested       = 1'b0;
        restart_scan();
    end

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            nested = 1'b0;
            restart_scan();
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == 1'b0) nested = pwdata[0];
            if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[7:0], m_tdata[8 +: LINE_WIDTH],
                        m_tdata[8 + LINE_WIDTH +: 2], m_tlast};
                seen_results++;
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result kind=%0d ch=%h line=%0d err=%0d last=%0d",
                                 $realtime, got.kind, got.ch, got.line, got.err, got.last);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: mismatch expected kind=%0d ch=%h line=%0d err=%0d last=%0d",
                                     $realtime, want.kind, want.ch, want.line, want.err,
                                     want.last);
                            $display("    got kind=%0d ch=%h line=%0d err=%0d last=%0d",
                                     got.kind, got.ch, got.line, got.err, got.last);
                        end
                    end
                end
            end
        end
    end

endmodule

/* tb/sv/tb_script_lexeme_splitter.sv */
// ----------------------------------------------------------------------------
// tb_script_lexeme_splitter
// Feeds source buffers into the lexeme splitter: hand-picked buffers for the
// comment, string, continuation and stop cases, then random buffers built
// from tokens, under both register settings and with random stalls on both
// sides. A separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_script_lexeme_splitter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_WIDTH = 20;
    localparam int IDLE_LIMIT = 3000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // [7:0] char, [27:8] line, [29:28] error
    logic [1:0]  m_tuser;   // item_kind
    logic        m_tlast;   // run_last
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    int errors, pending, seen_results;
    int bytes_sent = 0;
    int buffers_sent = 0;
    int idle_cycles = 0;
    logic [7:0] src[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    script_lexeme_splitter #(.LINE_WIDTH(LINE_WIDTH)) dut (.*);

    slx_lexeme_checker #(.LINE_WIDTH(LINE_WIDTH)) chk (.*);

    // Sends the buffer in src; its final byte carries tlast.
    task automatic send_buffer(bit no_gaps);
        int gap;
        for (int i = 0; i < src.size(); i++) begin
            gap = no_gaps ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                @(negedge aclk) s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk);
            s_tvalid = 1'b1;
            s_tdata  = src[i];
            s_tlast  = (i == src.size() - 1);
            do @(posedge aclk); while (!s_tready);
            bytes_sent++;
        end
        @(negedge aclk) s_tvalid = 1'b0;
        buffers_sent++;
        src.delete();
    endtask

    task automatic add_text(string t);
        for (int i = 0; i < t.len(); i++) src.push_back(t[i]);
    endtask

    task automatic add_token();
        string word_chars = "ABDLORTWZahi19:'.";
        int n;
        case ($urandom_range(0, 13))
            0, 1: begin
                n = $urandom_range(1, 5);
                repeat (n) src.push_back(word_chars[$urandom_range(0, word_chars.len() - 1)]);
                src.push_back(slx_pkg::CH_SPACE);
            end
            2: src.push_back(($urandom_range(0, 1) != 0) ? slx_pkg::CH_TAB : slx_pkg::CH_SPACE);
            3: case ($urandom_range(0, 2))
                0: src.push_back(slx_pkg::CH_CR);
                1: src.push_back(slx_pkg::CH_LF);
                default: add_text("\r\n");
            endcase
            4: src.push_back(slx_pkg::CH_COMMA);
            5: src.push_back(slx_pkg::CH_BANG);
            6: add_text("'Z");
            7: begin
                src.push_back(slx_pkg::CH_QUOTE);
                n = $urandom_range(0, 4);
                repeat (n) case ($urandom_range(0, 3))
                    0: add_text(":\"");
                    1: add_text("::");
                    default: src.push_back(8'($urandom_range(32'h21, 32'h7E)));
                endcase
                if ($urandom_range(0, 5) != 0) src.push_back(slx_pkg::CH_QUOTE);
                if ($urandom_range(0, 3) != 0) src.push_back(slx_pkg::CH_SPACE);
            end
            8: begin
                add_text("\nOBTW ");
                if ($urandom_range(0, 1) != 0) add_text("x\r\ny");
                if ($urandom_range(0, 4) != 0) add_text(" TLDR");
                if ($urandom_range(0, 3) != 0) add_text("  \n");
                else src.push_back(8'($urandom_range(0, 255)));
            end
            9: begin
                add_text("BTW q");
                src.push_back(slx_pkg::CH_LF);
            end
            10: begin
                if ($urandom_range(0, 1) != 0) add_text("...");
                else begin
                    src.push_back(slx_pkg::CH_ELL0);
                    src.push_back(slx_pkg::CH_ELL1);
                    src.push_back(slx_pkg::CH_ELL2);
                end
                add_text(($urandom_range(0, 1) != 0) ? "\r\n" : "\n");
                if ($urandom_range(0, 3) == 0) add_text(" \n");
                else add_text(" K ");
            end
            default: src.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic send_random_buffers(int target);
        int stop_at;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at) begin
            repeat ($urandom_range(1, 10)) add_token();
            send_buffer($urandom_range(0, 3) == 0);
        end
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        penable = 1'b0;
        @(negedge aclk) penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Register writes only happen once all results are out and the flush is over.
    task automatic wait_drained();
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Result side: random stalls, stretches without any, and one long hold-off
    // in the middle of the first random phase while bytes keep coming.
    initial begin
        int gap;
        bit no_gaps;
        bit held;
        no_gaps = 1'b0;
        held    = 1'b0;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
            gap = no_gaps ? 0 : $urandom_range(0, 18);
            if (!held && bytes_sent >= 100) begin
                held = 1'b1;
                gap  = 300;
            end
            if (gap > 0) begin
                @(negedge aclk) m_tready = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("timeout after %0d cycles without progress", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;

        // Directed buffers.
        add_text("OBTW x\nTLDR\n\"a:\"::\"\"!'Z,A\r\nB");
        send_buffer(1'b0);
        add_text("C...\r\n  \nD");
        send_buffer(1'b1);
        add_text("\"q\"x");
        send_buffer(1'b0);
        add_text("X OBTW TLDR Y\n");
        src.push_back(slx_pkg::CH_ELL0);
        src.push_back(slx_pkg::CH_ELL1);
        src.push_back(slx_pkg::CH_ELL2);
        add_text("\n E\t\"s");
        send_buffer(1'b0);
        add_text("\nOBTW TLDR z");
        send_buffer(1'b1);
        add_text("BTW \xff\n");
        src.push_back(8'hFF);
        src.push_back(slx_pkg::CH_NUL);
        add_text("Q!");
        send_buffer(1'b0);
        src.push_back(slx_pkg::CH_NUL);
        send_buffer(1'b0);
        src.push_back(8'hFF);
        send_buffer(1'b0);

        send_random_buffers(25);

        wait_drained();
        apb_write(3'd0, 32'h0000_0003);
        send_random_buffers(5);

        // An unused register index leaves the setting alone.
        wait_drained();
        apb_write(3'd4, 32'h0000_0000);
        send_random_buffers(5);

        wait_drained();
        apb_write(3'd0, 32'hFFFF_FFFE);
        send_random_buffers(10);

        wait_drained();
        repeat (30) @(posedge aclk);
        $display("covered %0d bytes in %0d buffers, %0d results checked",
                 bytes_sent, buffers_sent, seen_results);
        $display("both settings of the end-of-input lexeme, with stalls on both sides");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* script_lexeme_splitter.f */
rtl/slx_pkg.sv
rtl/slx_engine.sv
rtl/slx_result_fifo.sv
rtl/script_lexeme_splitter.sv
tb/sv/slx_lexeme_checker.sv
tb/sv/tb_script_lexeme_splitter.sv
